>>> src/lrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types, codes and constants for the link reconnect backoff supervisor.
// ----------------------------------------------------------------------------
package lrb_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NOW_BITS          = 32;
   localparam int RND_BITS          = 32;
   localparam int DELAY_BITS        = 16;
   localparam int FAIL_BITS         = 8;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [FAIL_BITS-1:0]  FAIL_MAX            = 8'd255;
   localparam logic [DELAY_BITS-1:0] RECOVERY_RESET_MS   = 16'd250;
   localparam logic [DELAY_BITS-1:0] BUDGET_RESET_MS     = 16'd4500;
   localparam logic [DELAY_BITS-1:0] BASE_RESET_MS       = 16'd1000;
   localparam logic [DELAY_BITS-1:0] CAP_RESET_MS        = 16'd30000;
   localparam logic [DELAY_BITS-1:0] TOTAL_CAP_RESET_MS  = 16'd60000;

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINK_RECOVERY = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONNECT_BUDGET = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BACKOFF_BASE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BACKOFF_CAP   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOTAL_CAP     = 3'd4;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_INIT  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'd0,
      MODE_IDLE    = 3'd1,
      MODE_CONN    = 3'd2,
      MODE_ONLINE  = 3'd3,
      MODE_BACKOFF = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_EVAL    = 2'd1,
      ST_BACKOFF = 2'd2,
      ST_FINISH  = 2'd3
   } top_state_type;

   typedef enum logic [1:0] {
      BO_IDLE   = 2'd0,
      BO_DOUBLE = 2'd1,
      BO_DIVIDE = 2'd2,
      BO_SUM    = 2'd3
   } bo_state_type;

   typedef struct packed {
      logic                 start;
      logic [FAIL_BITS-1:0] fails;
      logic [RND_BITS-1:0]  rnd;
   } bo_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DELAY_BITS-1:0] delay;
   } bo_rsp_type;

endpackage

>>> src/lrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_if
// Valid/ready channels of the supervisor: request, response and csr write.
// ----------------------------------------------------------------------------
interface lrb_req_if;
   import lrb_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [NOW_BITS-1:0] now_ms;
   logic                link_up;
   logic                session_up;
   logic                connect_busy;
   logic                connect_ok;
   logic [RND_BITS-1:0] random_word;

   modport source (output valid, cmd, now_ms, link_up, session_up, connect_busy,
                   connect_ok, random_word, input ready);
   modport sink   (input valid, cmd, now_ms, link_up, session_up, connect_busy,
                   connect_ok, random_word, output ready);
endinterface

interface lrb_rsp_if;
   import lrb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [2:0]            link_mode;
   logic                  start_connect;
   logic                  drop_session;
   logic                  request_time_sync;
   logic [FAIL_BITS-1:0]  failures;
   logic [DELAY_BITS-1:0] retry_delay_ms;

   modport source (output valid, link_mode, start_connect, drop_session,
                   request_time_sync, failures, retry_delay_ms, input ready);
   modport sink   (input valid, link_mode, start_connect, drop_session,
                   request_time_sync, failures, retry_delay_ms, output ready);
endinterface

interface lrb_csr_if;
   import lrb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/link_reconnect_backoff_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm
// Reconnect supervisor for a broker link with exponential backoff and jitter.
// ----------------------------------------------------------------------------
// Flow: a request is evaluated in ST_EVAL; a counted failure goes through the
//   backoff unit (doubling, bit-serial jitter modulo, sum) before ST_FINISH.
// Throughput: one request in flight; the next is taken the cycle after the
//   response is registered, later while that register is full.
// Reset: synchronous, active high; supervisor state and csr registers return
//   to their defaults, the response register empties.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm #(
   parameter int TIME_BITS = lrb_pkg::TIME_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lrb_req_if.sink   req_if,
   lrb_rsp_if.source rsp_if,
   lrb_csr_if.sink   csr_if
);
   import lrb_pkg::*;

   // ---------------- csr registers ----------------
   logic [DELAY_BITS-1:0] recovery_ms_ff;
   logic [DELAY_BITS-1:0] conn_limit_ff;
   logic [DELAY_BITS-1:0] base_ms_ff;
   logic [DELAY_BITS-1:0] cap_ms_ff;
   logic [DELAY_BITS-1:0] total_cap_ms_ff;

   // ---------------- captured request ----------------
   cmd_type               cmd_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic                  link_ff;
   logic                  sess_ff;
   logic                  busy_ff;
   logic                  ok_ff;
   logic [RND_BITS-1:0]   rnd_ff;

   // ---------------- supervisor state ----------------
   top_state_type         state_ff, state_in;
   logic                  service_ff, service_in;
   mode_type              mode_ff, mode_in;
   logic [TIME_BITS-1:0]  trans_time_ff, trans_time_in;
   logic [DELAY_BITS-1:0] wait_delay_ff, wait_delay_in;
   logic [TIME_BITS-1:0]  conn_start_ff, conn_start_in;
   logic [FAIL_BITS-1:0]  fail_count_ff, fail_count_in;
   logic                  conn_ff, conn_in;
   logic                  drop_ff, drop_in;
   logic                  sync_ff, sync_in;

   // ---------------- response register ----------------
   logic                  rsp_valid_ff, rsp_valid_in;
   mode_type              rsp_mode_ff;
   logic                  rsp_conn_ff;
   logic                  rsp_drop_ff;
   logic                  rsp_sync_ff;
   logic [FAIL_BITS-1:0]  rsp_fail_ff;
   logic [DELAY_BITS-1:0] rsp_delay_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic [TIME_BITS-1:0]  since_trans;
   logic [TIME_BITS-1:0]  since_conn;
   logic [FAIL_BITS-1:0]  fail_inc;
   bo_cmd_type            bo_cmd;
   bo_rsp_type            bo_rsp;

   // Configuration writes are taken at any time; unknown indexes are dropped.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         recovery_ms_ff  <= RECOVERY_RESET_MS;
         conn_limit_ff   <= BUDGET_RESET_MS;
         base_ms_ff      <= BASE_RESET_MS;
         cap_ms_ff       <= CAP_RESET_MS;
         total_cap_ms_ff <= TOTAL_CAP_RESET_MS;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_LINK_RECOVERY:  recovery_ms_ff  <= csr_if.data;
            REG_CONNECT_BUDGET: conn_limit_ff   <= csr_if.data;
            REG_BACKOFF_BASE:   base_ms_ff      <= csr_if.data;
            REG_BACKOFF_CAP:    cap_ms_ff       <= csr_if.data;
            REG_TOTAL_CAP:      total_cap_ms_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   // One request in flight; accept only when the sequencer is parked.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // Hold the request payload for the whole evaluation.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= cmd_type'(req_if.cmd);
         now_ff  <= TIME_BITS'(req_if.now_ms);
         link_ff <= req_if.link_up;
         sess_ff <= req_if.session_up;
         busy_ff <= req_if.connect_busy;
         ok_ff   <= req_if.connect_ok;
         rnd_ff  <= req_if.random_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         service_ff    <= 1'b0;
         mode_ff       <= MODE_WAIT;
         trans_time_ff <= '0;
         wait_delay_ff <= '0;
         conn_start_ff <= '0;
         fail_count_ff <= '0;
         conn_ff       <= 1'b0;
         drop_ff       <= 1'b0;
         sync_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         service_ff    <= service_in;
         mode_ff       <= mode_in;
         trans_time_ff <= trans_time_in;
         wait_delay_ff <= wait_delay_in;
         conn_start_ff <= conn_start_in;
         fail_count_ff <= fail_count_in;
         conn_ff       <= conn_in;
         drop_ff       <= drop_in;
         sync_ff       <= sync_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Load the response register from the settled state.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mode_ff  <= mode_ff;
         rsp_conn_ff  <= conn_ff;
         rsp_drop_ff  <= drop_ff;
         rsp_sync_ff  <= sync_ff;
         rsp_fail_ff  <= fail_count_ff;
         rsp_delay_ff <= wait_delay_ff;
      end
   end

   // Elapsed times wrap modulo 2^TIME_BITS.
   assign since_trans = now_ff - trans_time_ff;
   assign since_conn  = now_ff - conn_start_ff;
   assign fail_inc    = (fail_count_ff == FAIL_MAX) ? FAIL_MAX
                                                    : fail_count_ff + FAIL_BITS'(1);

   always_comb begin
      logic     go_on;
      logic     failed;
      mode_type m;

      state_in      = state_ff;
      service_in    = service_ff;
      mode_in       = mode_ff;
      trans_time_in = trans_time_ff;
      wait_delay_in = wait_delay_ff;
      conn_start_in = conn_start_ff;
      fail_count_in = fail_count_ff;
      conn_in       = conn_ff;
      drop_in       = drop_ff;
      sync_in       = sync_ff;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      bo_cmd        = '0;
      go_on         = 1'b1;
      failed        = 1'b0;
      m             = mode_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            // strobes live for one response only
            conn_in  = 1'b0;
            drop_in  = 1'b0;
            sync_in  = 1'b0;
            state_in = ST_FINISH;
            case (cmd_ff)
               CMD_INIT: begin
                  service_in    = 1'b0;
                  fail_count_in = '0;
                  trans_time_in = '0;
                  wait_delay_in = '0;
                  conn_start_in = '0;
                  mode_in       = link_ff ? MODE_IDLE : MODE_WAIT;
               end
               CMD_START: begin
                  if (!service_ff) begin
                     service_in    = 1'b1;
                     mode_in       = MODE_WAIT;
                     trans_time_in = now_ff;
                     wait_delay_in = recovery_ms_ff;
                     conn_start_in = '0;
                  end
               end
               CMD_STOP: begin
                  if (service_ff) begin
                     service_in    = 1'b0;
                     mode_in       = MODE_WAIT;
                     trans_time_in = '0;
                     wait_delay_in = '0;
                     conn_start_in = '0;
                     drop_in       = 1'b1;
                  end
               end
               default: begin
                  // tick: run the supervisor only while the service is on
                  if (service_ff) begin
                     if (!link_ff) begin
                        // link lost: drop the session and restart the wait
                        drop_in       = sess_ff;
                        mode_in       = MODE_WAIT;
                        trans_time_in = now_ff;
                        wait_delay_in = recovery_ms_ff;
                     end else begin
                        if (m == MODE_WAIT || m == MODE_BACKOFF) begin
                           if (since_trans < TIME_BITS'(wait_delay_ff)) begin
                              go_on = 1'b0;
                           end else begin
                              m = MODE_IDLE;
                           end
                        end
                        if (go_on && m == MODE_CONN) begin
                           go_on = 1'b0;
                           if (!busy_ff) begin
                              if (ok_ff && since_conn <= TIME_BITS'(conn_limit_ff)) begin
                                 fail_count_in = '0;
                                 m             = MODE_ONLINE;
                                 sync_in       = 1'b1;
                              end else begin
                                 // a late success still has to be torn down
                                 drop_in = ok_ff;
                                 failed  = 1'b1;
                              end
                           end
                        end
                        if (go_on && m == MODE_IDLE) begin
                           if (!sess_ff) begin
                              m             = MODE_CONN;
                              conn_start_in = now_ff;
                              conn_in       = 1'b1;
                              go_on         = 1'b0;
                           end else begin
                              // session already up: go online quietly
                              m = MODE_ONLINE;
                           end
                        end
                        if (go_on && m == MODE_ONLINE && !sess_ff) begin
                           failed = 1'b1;
                        end
                        if (failed) begin
                           // count the failure and hand the delay to the backoff unit
                           fail_count_in = fail_inc;
                           trans_time_in = now_ff;
                           m             = MODE_BACKOFF;
                           bo_cmd.start  = 1'b1;
                           bo_cmd.fails  = fail_inc;
                           bo_cmd.rnd    = rnd_ff;
                           state_in      = ST_BACKOFF;
                        end
                        mode_in = m;
                     end
                  end
               end
            endcase
         end

         ST_BACKOFF: begin
            if (bo_rsp.done) begin
               wait_delay_in = bo_rsp.delay;
               state_in      = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // advance once the output register is free or being drained
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   lrb_backoff_unit u_backoff (
      .clock        (clock),
      .reset        (reset),
      .bo_cmd       (bo_cmd),
      .base_ms      (base_ms_ff),
      .cap_ms       (cap_ms_ff),
      .total_cap_ms (total_cap_ms_ff),
      .bo_rsp       (bo_rsp)
   );

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.link_mode         = rsp_mode_ff;
   assign rsp_if.start_connect     = rsp_conn_ff;
   assign rsp_if.drop_session      = rsp_drop_ff;
   assign rsp_if.request_time_sync = rsp_sync_ff;
   assign rsp_if.failures          = rsp_fail_ff;
   assign rsp_if.retry_delay_ms    = rsp_delay_ff;

   // ---------------- assertions ----------------
   a_strobes_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_conn_ff, rsp_drop_ff, rsp_sync_ff}))
      else $error("more than one action strobe in a response");

   a_sync_online: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sync_ff) |-> (rsp_mode_ff == MODE_ONLINE && rsp_fail_ff == '0))
      else $error("time sync strobe outside a fresh online mode");

   a_connect_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_conn_ff) |-> (rsp_mode_ff == MODE_CONN))
      else $error("connect strobe without connecting mode");

   a_bo_start_idle: assert property (@(posedge clock) disable iff (reset)
      bo_cmd.start |-> !bo_rsp.busy)
      else $error("backoff unit started while busy");

   a_bo_done_wait: assert property (@(posedge clock) disable iff (reset)
      bo_rsp.done |-> (state_ff == ST_BACKOFF))
      else $error("backoff result with no waiting request");

endmodule

>>> src/lrb_backoff_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrb_backoff_unit
// Iterative backoff delay: doubling with cap, then jitter by restoring
// division one bit per cycle, then sum and total cap.
// ----------------------------------------------------------------------------
module lrb_backoff_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  lrb_pkg::bo_cmd_type               bo_cmd,
   input  logic [lrb_pkg::DELAY_BITS-1:0]    base_ms,
   input  logic [lrb_pkg::DELAY_BITS-1:0]    cap_ms,
   input  logic [lrb_pkg::DELAY_BITS-1:0]    total_cap_ms,
   output lrb_pkg::bo_rsp_type               bo_rsp
);
   import lrb_pkg::*;

   localparam int BASE_BITS = DELAY_BITS + 1;
   localparam int REM_BITS  = DELAY_BITS - 2;
   localparam int DIV_BITS  = REM_BITS + 1;
   localparam int BIT_BITS  = $clog2(RND_BITS);

   bo_state_type          state_ff, state_in;
   logic [BASE_BITS-1:0]  base_ff, base_in;
   logic [FAIL_BITS-1:0]  step_ff, step_in;
   logic [FAIL_BITS-1:0]  fails_ff, fails_in;
   logic [RND_BITS-1:0]   rnd_ff, rnd_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]   div_ff, div_in;
   logic [BIT_BITS-1:0]   bit_ff, bit_in;

   logic [BASE_BITS-1:0]  cap_ext;
   logic [BASE_BITS-1:0]  clamp;
   logic [DIV_BITS-1:0]   trial;
   logic [DIV_BITS-1:0]   trial_diff;
   logic [BASE_BITS-1:0]  total;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BO_IDLE;
      end else begin
         state_ff <= state_in;
      end
      base_ff  <= base_in;
      step_ff  <= step_in;
      fails_ff <= fails_in;
      rnd_ff   <= rnd_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      bit_ff   <= bit_in;
   end

   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      step_in    = step_ff;
      fails_in   = fails_ff;
      rnd_in     = rnd_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      bit_in     = bit_ff;
      bo_rsp     = '0;
      cap_ext    = {1'b0, cap_ms};
      clamp      = (base_ff > cap_ext) ? cap_ext : base_ff;
      trial      = {rem_ff, rnd_ff[RND_BITS-1]};
      trial_diff = trial - div_ff;
      total      = {1'b0, base_ff[DELAY_BITS-1:0]} + BASE_BITS'(rem_ff);

      bo_rsp.busy = (state_ff != BO_IDLE);

      case (state_ff)
         BO_IDLE: begin
            if (bo_cmd.start) begin
               // a zero failure count yields a zero delay through the same path
               base_in  = (bo_cmd.fails == '0) ? '0 : {1'b0, base_ms};
               step_in  = FAIL_BITS'(1);
               fails_in = bo_cmd.fails;
               rnd_in   = bo_cmd.rnd;
               state_in = BO_DOUBLE;
            end
         end
         BO_DOUBLE: begin
            if (step_ff >= fails_ff || base_ff == '0 || base_ff >= cap_ext) begin
               base_in  = clamp;
               div_in   = {1'b0, clamp[DELAY_BITS-1:2]} + DIV_BITS'(1);
               rem_in   = '0;
               bit_in   = BIT_BITS'(RND_BITS - 1);
               state_in = BO_DIVIDE;
            end else begin
               base_in = base_ff << 1;
               step_in = step_ff + FAIL_BITS'(1);
            end
         end
         BO_DIVIDE: begin
            rem_in = (trial >= div_ff) ? trial_diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
            rnd_in = rnd_ff << 1;
            bit_in = bit_ff - BIT_BITS'(1);
            if (bit_ff == '0) begin
               state_in = BO_SUM;
            end
         end
         BO_SUM: begin
            bo_rsp.done  = 1'b1;
            bo_rsp.delay = (total > {1'b0, total_cap_ms}) ? total_cap_ms
                                                          : total[DELAY_BITS-1:0];
            state_in     = BO_IDLE;
         end
         default: begin
            state_in = BO_IDLE;
         end
      endcase
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the link reconnect backoff supervisor. Commands go
// in on the request channel while a cycle-free software copy of the supervisor
// predicts the status word of each one; the response channel is compared
// field by field in order. Both channels stall in random bursts, and the
// backoff registers are swept through zero, one, all-ones, defaults and
// random values between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
   import lrb_pkg::*;

   // Run limit: 10 ms covers several times the slowest legal run (about 1.8k
   // requests, each through the backoff path plus both stalls).
   localparam int  CLOCK_HALF_NS = 6;
   localparam int  RESET_CYCLES  = 12;
   localparam int  TAIL_CYCLES   = 60;
   localparam real TIMEOUT_NS    = 10_000_000.0;

   typedef struct packed {
      cmd_type             cmd;
      logic [NOW_BITS-1:0] now_ms;
      logic                link_up;
      logic                session_up;
      logic                connect_busy;
      logic                connect_ok;
      logic [RND_BITS-1:0] random_word;
   } link_cmd_type;

   typedef struct packed {
      mode_type              link_mode;
      logic                  start_connect;
      logic                  drop_session;
      logic                  request_time_sync;
      logic [FAIL_BITS-1:0]  failures;
      logic [DELAY_BITS-1:0] retry_delay_ms;
   } link_status_type;

   logic clock;
   logic reset;

   lrb_req_if req_ch ();
   lrb_rsp_if rsp_ch ();
   lrb_csr_if csr_ch ();

   link_reconnect_backoff_fsm u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // ------------------------------------------------------------------------
   // Supervisor copy: registers and state, updated once per accepted request
   // ------------------------------------------------------------------------
   logic [DELAY_BITS-1:0] recovery_ms;
   logic [DELAY_BITS-1:0] conn_limit_ms;
   logic [DELAY_BITS-1:0] base_ms;
   logic [DELAY_BITS-1:0] cap_ms;
   logic [DELAY_BITS-1:0] total_cap_ms;

   logic                  service_on;
   mode_type              cur_mode;
   logic [NOW_BITS-1:0]   mark_ms;      // time of the last mode change that arms a wait
   logic [DELAY_BITS-1:0] wait_ms;
   logic [NOW_BITS-1:0]   connect_t0_ms;
   logic [FAIL_BITS-1:0]  fail_count;

   link_status_type pending_status[$]; // predicted status words, oldest first
   int           error_count;
   int           status_count;
   logic         idling_on;            // random stalls on both channels
   logic [NOW_BITS-1:0] wall_ms;       // running timestamp fed to the block

   // Doubled base, capped, plus jitter in 0..base/4, capped again.
   function automatic logic [DELAY_BITS-1:0] calc_retry_delay(logic [FAIL_BITS-1:0] fails,
                                                              logic [RND_BITS-1:0] rnd);
      logic [31:0] base;
      logic [31:0] window;
      logic [31:0] jitter;
      logic [31:0] total;
      int          k;
      if (fails == 0) return '0;
      base = {16'd0, base_ms};
      k    = 1;
      while (k < fails && base < {16'd0, cap_ms}) begin
         base = base * 2;
         k++;
      end
      if (base > {16'd0, cap_ms}) base = {16'd0, cap_ms};
      window = base / 4;
      jitter = (window > 0) ? (rnd % (window + 1)) : 32'd0;
      total  = base + jitter;
      if (total > {16'd0, total_cap_ms}) total = {16'd0, total_cap_ms};
      return total[DELAY_BITS-1:0];
   endfunction

   function automatic void note_failure(logic [NOW_BITS-1:0] now, logic [RND_BITS-1:0] rnd);
      if (fail_count != FAIL_MAX) fail_count = fail_count + FAIL_BITS'(1);
      wait_ms  = calc_retry_delay(fail_count, rnd);
      mark_ms  = now;
      cur_mode = MODE_BACKOFF;
   endfunction

   function automatic link_status_type advance_supervisor(link_cmd_type rq);
      link_status_type     st;
      logic                finished;
      logic [NOW_BITS-1:0] elapsed;
      st          = '0;
      finished    = 1'b0;
      case (rq.cmd)
         CMD_INIT: begin
            service_on    = 1'b0;
            fail_count    = '0;
            mark_ms       = '0;
            wait_ms       = '0;
            connect_t0_ms = '0;
            cur_mode      = rq.link_up ? MODE_IDLE : MODE_WAIT;
         end
         CMD_START: begin
            if (!service_on) begin
               service_on    = 1'b1;
               cur_mode      = MODE_WAIT;
               mark_ms       = rq.now_ms;
               wait_ms       = recovery_ms;
               connect_t0_ms = '0;
            end
         end
         CMD_STOP: begin
            // failure count survives a stop
            if (service_on) begin
               service_on       = 1'b0;
               cur_mode         = MODE_WAIT;
               mark_ms          = '0;
               wait_ms          = '0;
               connect_t0_ms    = '0;
               st.drop_session  = 1'b1;
            end
         end
         default: begin
            if (service_on) begin
               if (!rq.link_up) begin
                  st.drop_session = rq.session_up;
                  cur_mode        = MODE_WAIT;
                  mark_ms         = rq.now_ms;
                  wait_ms         = recovery_ms;
                  finished        = 1'b1;
               end
               if (!finished && (cur_mode == MODE_WAIT || cur_mode == MODE_BACKOFF)) begin
                  elapsed = rq.now_ms - mark_ms;
                  if (elapsed < {16'd0, wait_ms}) finished = 1'b1;
                  else cur_mode = MODE_IDLE;
               end
               if (!finished && cur_mode == MODE_CONN) begin
                  finished = 1'b1;
                  if (!rq.connect_busy) begin
                     elapsed = rq.now_ms - connect_t0_ms;
                     if (rq.connect_ok && elapsed <= {16'd0, conn_limit_ms}) begin
                        fail_count           = '0;
                        cur_mode             = MODE_ONLINE;
                        st.request_time_sync = 1'b1;
                     end else begin
                        // a late success still has to be torn down
                        if (rq.connect_ok) st.drop_session = 1'b1;
                        note_failure(rq.now_ms, rq.random_word);
                     end
                  end
               end
               if (!finished && cur_mode == MODE_IDLE) begin
                  if (!rq.session_up) begin
                     cur_mode         = MODE_CONN;
                     connect_t0_ms    = rq.now_ms;
                     st.start_connect = 1'b1;
                     finished         = 1'b1;
                  end else begin
                     cur_mode = MODE_ONLINE;
                  end
               end
               if (!finished && cur_mode == MODE_ONLINE && !rq.session_up)
                  note_failure(rq.now_ms, rq.random_word);
            end
         end
      endcase
      st.link_mode      = cur_mode;
      st.failures       = fail_count;
      st.retry_delay_ms = wait_ms;
      return st;
   endfunction

   // ------------------------------------------------------------------------
   // Clock and the response side
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Response ready: random stall bursts while idling is on.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left   = $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("MISMATCH status %0d %s: got %0h expected %0h", status_count, what, got, want);
   endtask

   // Compare every accepted status word against the oldest prediction.
   initial begin
      link_status_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_status.size() == 0) begin
               report_mismatch("unexpected status", 32'(rsp_ch.link_mode), '0);
            end else begin
               want = pending_status.pop_front();
               if (rsp_ch.link_mode !== want.link_mode)
                  report_mismatch("link_mode", 32'(rsp_ch.link_mode), 32'(want.link_mode));
               if (rsp_ch.start_connect !== want.start_connect)
                  report_mismatch("start_connect", 32'(rsp_ch.start_connect),
                                  32'(want.start_connect));
               if (rsp_ch.drop_session !== want.drop_session)
                  report_mismatch("drop_session", 32'(rsp_ch.drop_session),
                                  32'(want.drop_session));
               if (rsp_ch.request_time_sync !== want.request_time_sync)
                  report_mismatch("request_time_sync", 32'(rsp_ch.request_time_sync),
                                  32'(want.request_time_sync));
               if (rsp_ch.failures !== want.failures)
                  report_mismatch("failures", 32'(rsp_ch.failures), 32'(want.failures));
               if (rsp_ch.retry_delay_ms !== want.retry_delay_ms)
                  report_mismatch("retry_delay_ms", 32'(rsp_ch.retry_delay_ms),
                                  32'(want.retry_delay_ms));
            end
            status_count++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Present one request and hold it until taken. Valid stays high on return so
   // a back-to-back request never lowers and raises it in the same step; any
   // caller that pauses afterwards must drop it first.
   task automatic send_request(link_cmd_type rq);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap          = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= rq.cmd;
      req_ch.now_ms       <= rq.now_ms;
      req_ch.link_up      <= rq.link_up;
      req_ch.session_up   <= rq.session_up;
      req_ch.connect_busy <= rq.connect_busy;
      req_ch.connect_ok   <= rq.connect_ok;
      req_ch.random_word  <= rq.random_word;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // taken at this edge: predict now, ahead of its response
      pending_status.push_back(advance_supervisor(rq));
   endtask

   task automatic send_fields(cmd_type cmd, logic [NOW_BITS-1:0] now, logic link,
                              logic sess, logic busy, logic ok, logic [RND_BITS-1:0] rnd);
      link_cmd_type rq;
      rq.cmd          = cmd;
      rq.now_ms       = now;
      rq.link_up      = link;
      rq.session_up   = sess;
      rq.connect_busy = busy;
      rq.connect_ok   = ok;
      rq.random_word  = rnd;
      wall_ms         = now;
      send_request(rq);
   endtask

   // Drop valid and hold off until every predicted status has been seen.
   task automatic wait_all_status();
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // Write all five registers plus one write to an unused index; only call
   // with nothing in flight.
   task automatic load_config(logic [DELAY_BITS-1:0] recovery, logic [DELAY_BITS-1:0] budget,
                              logic [DELAY_BITS-1:0] base, logic [DELAY_BITS-1:0] cap,
                              logic [DELAY_BITS-1:0] total_cap);
      logic [CSR_INDEX_BITS-1:0] idx[6];
      logic [CSR_DATA_BITS-1:0]  val[6];
      int                        n;
      idx[0] = CSR_INDEX_BITS'($urandom_range(5, 7));
      val[0] = CSR_DATA_BITS'($urandom);
      idx[1] = REG_LINK_RECOVERY;   val[1] = recovery;
      idx[2] = REG_CONNECT_BUDGET;  val[2] = budget;
      idx[3] = REG_BACKOFF_BASE;    val[3] = base;
      idx[4] = REG_BACKOFF_CAP;     val[4] = cap;
      idx[5] = REG_TOTAL_CAP;       val[5] = total_cap;
      for (n = 0; n < 6; n++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[n];
         csr_ch.data  <= val[n];
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         case (idx[n])
            REG_LINK_RECOVERY:  recovery_ms   = val[n];
            REG_CONNECT_BUDGET: conn_limit_ms = val[n];
            REG_BACKOFF_BASE:   base_ms       = val[n];
            REG_BACKOFF_CAP:    cap_ms        = val[n];
            REG_TOTAL_CAP:      total_cap_ms  = val[n];
            default: ;  // unused index: dropped by the block
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [RND_BITS-1:0] jitter_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DELAY_BITS-1:0] pick_setting(logic [DELAY_BITS-1:0] dflt);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'd1;
         2:       return '1;
         3:       return dflt;
         4:       return DELAY_BITS'($urandom_range(0, 300));
         default: return DELAY_BITS'($urandom);
      endcase
   endfunction

   // Mostly well-formed traffic that follows the predicted mode: start when
   // stopped, run the wait to its exact edges, let connects finish inside and
   // just outside the budget, drop sessions while online. A small share is
   // fully random noise, stops and inits.
   task automatic run_link_traffic(int n_items);
      link_cmd_type rq;
      int        i;
      int        pick;
      for (i = 0; i < n_items; i++) begin
         rq.cmd          = cmd_type'($urandom_range(0, 3));
         rq.now_ms       = ($urandom_range(0, 39) == 0) ? NOW_BITS'($urandom)
                                                       : wall_ms + $urandom_range(0, 3000);
         rq.link_up      = 1'($urandom_range(0, 1));
         rq.session_up   = 1'($urandom_range(0, 1));
         rq.connect_busy = 1'($urandom_range(0, 1));
         rq.connect_ok   = 1'($urandom_range(0, 1));
         rq.random_word  = jitter_word();
         pick            = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise: keep the random fields as drawn
         end else if (!service_on) begin
            rq.cmd = ($urandom_range(0, 4) == 0) ? CMD_INIT : CMD_START;
         end else if (pick < 10) begin
            rq.cmd = CMD_STOP;
         end else if (pick < 11) begin
            rq.cmd = CMD_INIT;
         end else begin
            rq.cmd     = CMD_TICK;
            rq.link_up = ($urandom_range(0, 29) != 0);
            case (cur_mode)
               MODE_WAIT, MODE_BACKOFF: begin
                  rq.session_up = ($urandom_range(0, 4) == 0);
                  case ($urandom_range(0, 3))
                     0:       rq.now_ms = mark_ms + wait_ms - 1;
                     1:       rq.now_ms = mark_ms + wait_ms;
                     default: rq.now_ms = wall_ms + $urandom_range(0, 4000);
                  endcase
               end
               MODE_CONN: begin
                  rq.session_up   = ($urandom_range(0, 7) == 0);
                  rq.connect_busy = ($urandom_range(0, 2) == 0);
                  rq.connect_ok   = ($urandom_range(0, 3) != 0);
                  case ($urandom_range(0, 4))
                     0:       rq.now_ms = connect_t0_ms + conn_limit_ms;
                     1:       rq.now_ms = connect_t0_ms + conn_limit_ms + 1;
                     default: rq.now_ms = wall_ms + $urandom_range(0, 800);
                  endcase
               end
               default: begin
                  rq.session_up = ($urandom_range(0, 9) != 0);
                  rq.now_ms     = wall_ms + $urandom_range(0, 5000);
               end
            endcase
         end
         wall_ms = rq.now_ms;
         send_request(rq);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Commands that must do nothing or only reset state, with extreme fields.
   task automatic test_stopped_commands();
      send_fields(CMD_TICK,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_fields(CMD_STOP,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_fields(CMD_INIT,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_INIT,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_START, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      // second start must be ignored
      send_fields(CMD_START, 32'h0000_1000, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
   endtask

   // One pass through every mode, with each wait and budget hit at its edge.
   task automatic test_connect_lifecycle();
      // last millisecond of the recovery wait, then the first one past it
      send_fields(CMD_TICK, mark_ms + wait_ms - 1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_TICK, mark_ms + wait_ms, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_TICK, connect_t0_ms + 50, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0);
      // success exactly at the budget edge goes online with a sync strobe
      send_fields(CMD_TICK, connect_t0_ms + conn_limit_ms, 1'b1, 1'b0, 1'b0, 1'b1, 32'h0);
      send_fields(CMD_TICK, wall_ms + 100, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0);
      // session lost while online: first failure, all-ones random word
      send_fields(CMD_TICK, wall_ms + 100, 1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_fields(CMD_TICK, mark_ms + wait_ms - 1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      // backoff over with the session already up: online, no sync strobe
      send_fields(CMD_TICK, mark_ms + wait_ms, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0);
      // link loss with the session up must drop it
      send_fields(CMD_TICK, wall_ms + 10, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_TICK, mark_ms + wait_ms, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      // success one past the budget: drop plus failure
      send_fields(CMD_TICK, connect_t0_ms + conn_limit_ms + 1, 1'b1, 1'b0, 1'b0, 1'b1,
                  32'h1234_5678);
      send_fields(CMD_TICK, mark_ms + wait_ms, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_TICK, connect_t0_ms + 10, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      // stop keeps the failure count
      send_fields(CMD_STOP, wall_ms, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0);
      // recovery wait across the timestamp wrap
      send_fields(CMD_START, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_TICK, 32'h0000_00F0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
      send_fields(CMD_INIT, 32'h0000_00F0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0);
   endtask

   // Back-to-back failures until the counter pins at its maximum and stays.
   task automatic test_failure_saturation();
      int                  i;
      logic                ok;
      logic [NOW_BITS-1:0] t;
      send_fields(CMD_START, wall_ms, 1'b1, 1'b0, 1'b0, 1'b0, jitter_word());
      for (i = 0; i < 540; i++) begin
         if (cur_mode == MODE_CONN) begin
            ok = 1'($urandom_range(0, 1));
            t  = ok ? connect_t0_ms + conn_limit_ms + 1 + $urandom_range(0, 50)
                    : connect_t0_ms + $urandom_range(0, 100);
            send_fields(CMD_TICK, t, 1'b1, 1'b0, 1'b0, ok, jitter_word());
         end else begin
            t = mark_ms + wait_ms + $urandom_range(0, 3);
            send_fields(CMD_TICK, t, 1'b1, 1'b0, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), jitter_word());
         end
      end
   endtask

   // Traffic phases under swept register settings: all zero, all ones, then
   // random mixes of extremes, defaults and random values. Each phase
   // boundary drains the block completely before the registers change.
   task automatic test_register_settings();
      int ph;
      for (ph = 0; ph < 6; ph++) begin
         wait_all_status();
         case (ph)
            0:       load_config('0, '0, '0, '0, '0);
            1:       load_config('1, '1, '1, '1, '1);
            default: load_config(pick_setting(RECOVERY_RESET_MS), pick_setting(BUDGET_RESET_MS),
                                 pick_setting(BASE_RESET_MS), pick_setting(CAP_RESET_MS),
                                 pick_setting(TOTAL_CAP_RESET_MS));
         endcase
         run_link_traffic(175);
      end
   endtask

   // Last stretch at full rate: no stalls on either side, default settings.
   task automatic test_quiet_finish();
      wait_all_status();
      idling_on = 1'b0;
      load_config(RECOVERY_RESET_MS, BUDGET_RESET_MS, BASE_RESET_MS, CAP_RESET_MS,
                  TOTAL_CAP_RESET_MS);
      run_link_traffic(150);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      recovery_ms   = RECOVERY_RESET_MS;
      conn_limit_ms = BUDGET_RESET_MS;
      base_ms       = BASE_RESET_MS;
      cap_ms        = CAP_RESET_MS;
      total_cap_ms  = TOTAL_CAP_RESET_MS;
      service_on    = 1'b0;
      cur_mode      = MODE_WAIT;
      mark_ms       = '0;
      wait_ms       = '0;
      connect_t0_ms = '0;
      fail_count    = '0;
      error_count   = 0;
      status_count  = 0;
      idling_on     = 1'b1;
      wall_ms       = '0;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= CMD_TICK;
      req_ch.now_ms       <= '0;
      req_ch.link_up      <= 1'b0;
      req_ch.session_up   <= 1'b0;
      req_ch.connect_busy <= 1'b0;
      req_ch.connect_ok   <= 1'b0;
      req_ch.random_word  <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= REG_LINK_RECOVERY;
      csr_ch.data         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_stopped_commands();
      test_connect_lifecycle();
      test_failure_saturation();
      test_register_settings();
      test_quiet_finish();

      // drain, then give a late or stray status word time to show up
      wait_all_status();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("link_reconnect_backoff_fsm verification clean");
      end else begin
         $display("link_reconnect_backoff_fsm verification failed");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("link_reconnect_backoff_fsm verification failed");
      $finish;
   end

endmodule
